### rtl/core/bfdr_pkg.sv
package bfdr_pkg;

    // payload capacity and derived widths
    localparam int MAX_PAYLOAD = 64;
    localparam int ADDR_W      = 6;
    localparam int LEN_W       = 7;

    // input queue between front and engine
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = QPTR_W + 1;

    // configuration register indexes and reset values
    localparam logic REG_START_MARKER = 1'b0;
    localparam logic REG_END_MARKER   = 1'b1;
    localparam logic [7:0] START_MARKER_RESET = 8'hff;
    localparam logic [7:0] END_MARKER_RESET   = 8'h00;

    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_PAYLOAD);

    typedef enum logic [5:0] {
        PH_IDLE       = 6'b000001,
        PH_GET_ID     = 6'b000010,
        PH_GET_LENGTH = 6'b000100,
        PH_GET_DATA   = 6'b001000,
        PH_GET_END    = 6'b010000,
        PH_ERROR      = 6'b100000
    } phase_t;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       is_start;
        logic       is_end;
    } qitem_t;

    typedef struct packed {
        logic [7:0]       frame_id;
        logic [LEN_W-1:0] frame_length;
        logic [ADDR_W-1:0] byte_index;
        logic [7:0]       data_byte;
        logic             has_data;
        logic             last_of_frame;
    } result_t;

endpackage

### rtl/core/bfdr_front.sv
module bfdr_front (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [7:0]       s_tdata,
    input  logic [7:0]       start_marker,
    input  logic [7:0]       end_marker,
    output logic             q_valid,
    output bfdr_pkg::qitem_t q_item,
    input  logic             q_pop
);
    import bfdr_pkg::*;

    qitem_t            fifo_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              push;
    logic              pop;
    qitem_t            in_item;

    assign s_tready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign q_valid  = (count_reg != '0);
    assign push     = s_tvalid & s_tready;
    assign pop      = q_pop & q_valid;
    assign q_item   = fifo_reg[rd_ptr_reg];

    // classify the byte against both markers on the way in
    always_comb begin
        in_item.rx_byte  = s_tdata;
        in_item.is_start = (s_tdata == start_marker);
        in_item.is_end   = (s_tdata == end_marker);
    end

    always_comb begin
        count_next = count_reg + QCNT_W'(push) - QCNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

### rtl/core/bfdr_engine.sv
module bfdr_engine (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [7:0]        start_marker,
    input  logic [7:0]        end_marker,
    input  logic              q_valid,
    input  bfdr_pkg::qitem_t  q_item,
    output logic              q_pop,
    output logic              res_valid,
    output bfdr_pkg::result_t res_data,
    input  logic              res_ready
);
    import bfdr_pkg::*;

    typedef enum logic [8:0] {
        SQ_IDLE  = 9'b000000001,
        SQ_RREQ  = 9'b000000010,
        SQ_RFEED = 9'b000000100,
        SQ_SCAN  = 9'b000001000,
        SQ_SCMP  = 9'b000010000,
        SQ_MOVE  = 9'b000100000,
        SQ_MOVEW = 9'b001000000,
        SQ_ERD   = 9'b010000000,
        SQ_EPUSH = 9'b100000000
    } seq_t;

    seq_t              seq_reg, seq_next;
    phase_t            phase_reg, phase_next;
    logic [7:0]        held_id_reg, held_id_next;
    logic [LEN_W-1:0]  held_length_reg, held_length_next;
    logic [LEN_W-1:0]  fill_reg, fill_next;
    logic [LEN_W-1:0]  rp_reg, rp_next;
    logic [LEN_W-1:0]  rl_reg, rl_next;
    logic [LEN_W-1:0]  scan_reg, scan_next;
    logic [LEN_W-1:0]  dst_reg, dst_next;
    logic [ADDR_W-1:0] emit_reg, emit_next;

    logic [7:0]        payload_reg [MAX_PAYLOAD];
    logic [7:0]        mem_q_reg;
    logic              mem_we, mem_re;
    logic [ADDR_W-1:0] mem_waddr, mem_raddr;
    logic [7:0]        mem_wdata;

    // byte fed to the parser and what it does
    logic [7:0]        fb;
    logic              fb_start, fb_end;
    phase_t            f_phase;
    logic [7:0]        f_id;
    logic [LEN_W-1:0]  f_len;
    logic [LEN_W-1:0]  f_fill;
    logic [LEN_W-1:0]  fill_inc;
    logic              f_we, f_emit, f_resync;
    logic              emit_last;

    always_comb begin
        if (seq_reg == SQ_RFEED) begin
            fb       = mem_q_reg;
            fb_start = (mem_q_reg == start_marker);
            fb_end   = (mem_q_reg == end_marker);
        end else begin
            fb       = q_item.rx_byte;
            fb_start = q_item.is_start;
            fb_end   = q_item.is_end;
        end
    end

    always_comb begin
        f_phase  = phase_reg;
        f_id     = held_id_reg;
        f_len    = held_length_reg;
        f_fill   = fill_reg;
        f_we     = 1'b0;
        f_emit   = 1'b0;
        f_resync = 1'b0;
        fill_inc = fill_reg + LEN_W'(1);
        case (phase_reg)
            PH_GET_ID: begin
                f_id    = fb;
                f_phase = PH_GET_LENGTH;
            end
            PH_GET_LENGTH: begin
                if (fb == 8'd0) begin
                    f_len   = '0;
                    f_phase = PH_GET_END;
                end else if (fb > {1'b0, MAX_LEN}) begin
                    f_phase = PH_ERROR;
                end else begin
                    f_len   = fb[LEN_W-1:0];
                    f_fill  = '0;
                    f_phase = PH_GET_DATA;
                end
            end
            PH_GET_DATA: begin
                f_we = (fill_reg < MAX_LEN);
                if (fill_inc >= held_length_reg) begin
                    f_fill  = '0;
                    f_phase = PH_GET_END;
                end else begin
                    f_fill = fill_inc;
                end
            end
            PH_GET_END: begin
                if (fb_end) begin
                    f_emit = 1'b1;
                end else if (fb_start) begin
                    f_phase = PH_GET_ID;
                end else begin
                    f_resync = 1'b1;
                end
            end
            default: begin
                f_phase = fb_start ? PH_GET_ID : PH_ERROR;
            end
        endcase
    end

    assign emit_last = (held_length_reg == '0) ||
                       ({1'b0, emit_reg} + LEN_W'(1) == held_length_reg);

    always_comb begin
        res_data.frame_id      = held_id_reg;
        res_data.frame_length  = held_length_reg;
        res_data.has_data      = (held_length_reg != '0);
        res_data.byte_index    = res_data.has_data ? emit_reg : '0;
        res_data.data_byte     = res_data.has_data ? mem_q_reg : 8'd0;
        res_data.last_of_frame = emit_last;
    end

    always_comb begin
        seq_next         = seq_reg;
        phase_next       = phase_reg;
        held_id_next     = held_id_reg;
        held_length_next = held_length_reg;
        fill_next        = fill_reg;
        rp_next          = rp_reg;
        rl_next          = rl_reg;
        scan_next        = scan_reg;
        dst_next         = dst_reg;
        emit_next        = emit_reg;
        mem_we           = 1'b0;
        mem_re           = 1'b0;
        mem_waddr        = fill_reg[ADDR_W-1:0];
        mem_wdata        = fb;
        mem_raddr        = rp_reg[ADDR_W-1:0];
        q_pop            = 1'b0;
        res_valid        = 1'b0;

        case (seq_reg)
            SQ_IDLE, SQ_RFEED: begin
                if (seq_reg == SQ_RFEED || q_valid) begin
                    q_pop            = (seq_reg == SQ_IDLE);
                    phase_next       = f_phase;
                    held_id_next     = f_id;
                    held_length_next = f_len;
                    fill_next        = f_fill;
                    mem_we           = f_we;
                    seq_next         = (seq_reg == SQ_RFEED) ? SQ_RREQ : SQ_IDLE;
                    if (f_emit) begin
                        phase_next = PH_IDLE;
                        rp_next    = '0;
                        rl_next    = '0;
                        emit_next  = '0;
                        seq_next   = (held_length_reg == '0) ? SQ_EPUSH : SQ_ERD;
                    end else if (f_resync) begin
                        phase_next = PH_ERROR;
                        scan_next  = held_length_reg;
                        seq_next   = SQ_SCAN;
                    end
                end
            end
            SQ_RREQ: begin
                // fetch the next pending byte, or close the step
                if (rp_reg < rl_reg && !rp_reg[LEN_W-1]) begin
                    mem_re   = 1'b1;
                    rp_next  = rp_reg + LEN_W'(1);
                    seq_next = SQ_RFEED;
                end else begin
                    rp_next  = '0;
                    rl_next  = '0;
                    seq_next = SQ_IDLE;
                end
            end
            SQ_SCAN: begin
                if (scan_reg == '0) begin
                    seq_next = SQ_RREQ;
                end else begin
                    mem_re    = 1'b1;
                    mem_raddr = ADDR_W'(scan_reg - LEN_W'(1));
                    seq_next  = SQ_SCMP;
                end
            end
            SQ_SCMP: begin
                if (mem_q_reg == start_marker) begin
                    phase_next = PH_GET_ID;
                    if (rl_reg > rp_reg && rl_reg <= MAX_LEN &&
                        held_length_reg <= rp_reg) begin
                        // pending bytes slide down to follow the new span
                        dst_next = held_length_reg;
                        seq_next = SQ_MOVE;
                    end else begin
                        rp_next  = scan_reg;
                        rl_next  = held_length_reg;
                        seq_next = SQ_RREQ;
                    end
                end else begin
                    scan_next = scan_reg - LEN_W'(1);
                    seq_next  = SQ_SCAN;
                end
            end
            SQ_MOVE: begin
                mem_re   = 1'b1;
                rp_next  = rp_reg + LEN_W'(1);
                seq_next = SQ_MOVEW;
            end
            SQ_MOVEW: begin
                mem_we    = 1'b1;
                mem_waddr = dst_reg[ADDR_W-1:0];
                mem_wdata = mem_q_reg;
                dst_next  = dst_reg + LEN_W'(1);
                if (rp_reg == rl_reg) begin
                    rp_next  = scan_reg;
                    rl_next  = dst_reg + LEN_W'(1);
                    seq_next = SQ_RREQ;
                end else begin
                    seq_next = SQ_MOVE;
                end
            end
            SQ_ERD: begin
                mem_re    = 1'b1;
                mem_raddr = emit_reg;
                seq_next  = SQ_EPUSH;
            end
            SQ_EPUSH: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    if (emit_last) begin
                        seq_next = SQ_IDLE;
                    end else begin
                        emit_next = emit_reg + ADDR_W'(1);
                        seq_next  = SQ_ERD;
                    end
                end
            end
            default: begin
                seq_next = SQ_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seq_reg         <= SQ_IDLE;
            phase_reg       <= PH_IDLE;
            held_id_reg     <= '0;
            held_length_reg <= '0;
            fill_reg        <= '0;
            rp_reg          <= '0;
            rl_reg          <= '0;
            scan_reg        <= '0;
            dst_reg         <= '0;
            emit_reg        <= '0;
        end else begin
            seq_reg         <= seq_next;
            phase_reg       <= phase_next;
            held_id_reg     <= held_id_next;
            held_length_reg <= held_length_next;
            fill_reg        <= fill_next;
            rp_reg          <= rp_next;
            rl_reg          <= rl_next;
            scan_reg        <= scan_next;
            dst_reg         <= dst_next;
            emit_reg        <= emit_next;
        end
    end

    // payload store, one write and one registered read per cycle
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            payload_reg[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            mem_q_reg <= payload_reg[mem_raddr];
        end
    end

endmodule

### rtl/core/bfdr_out.sv
module bfdr_out (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              res_valid,
    input  bfdr_pkg::result_t res_data,
    output logic              res_ready,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [31:0]       m_tdata,
    output logic              m_tuser,
    output logic              m_tlast
);
    import bfdr_pkg::*;

    logic    valid_reg;
    result_t data_reg;

    assign res_ready = !valid_reg || m_tready;
    assign m_tvalid  = valid_reg;
    assign m_tdata   = {3'b000, data_reg.data_byte, data_reg.byte_index,
                        data_reg.frame_length, data_reg.frame_id};
    assign m_tuser   = data_reg.has_data;
    assign m_tlast   = data_reg.last_of_frame;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (res_ready) begin
            valid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_ready && res_valid) begin
            data_reg <= res_data;
        end
    end

endmodule

### rtl/core/byte_frame_deframer_resync_top.sv
// Byte-stream frame parser: frames are start marker, id, length, payload, end
// marker. A correct frame leaves as one item per payload byte (tuser high), or
// as a single item with tuser low for length zero, tlast on the final item. A
// wrong end marker that equals the start marker restarts the frame; any other
// wrong end marker rescans the stored payload backward for its last start
// marker and replays the bytes after it before taking the next received byte,
// or drops to error when there is none. Lengths above 64 are errors. Received
// bytes go into a four-entry queue, so the input can keep flowing while the
// parser engine is busy until the queue is full. A plain byte goes straight
// from the queue to the parser; each replayed, moved or scanned byte and each
// emitted item needs a read step and then a use step, set by the payload
// memory with its registered read. Markers are set over APB at byte addresses
// 0 (start, reset 0xff) and 4 (end, reset 0x00); the user must set them only
// while idle, and the block itself does not enforce this.
module byte_frame_deframer_resync_top (
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [7:0] frame_id, [14:8] frame_length,
                                   // [20:15] byte_index, [28:21] data_byte
    output logic        m_tuser,   // [0] has_data
    output logic        m_tlast,   // last_of_frame
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import bfdr_pkg::*;

    logic [7:0] start_marker_reg;
    logic [7:0] end_marker_reg;
    logic       cfg_write;

    logic    q_valid;
    qitem_t  q_item;
    logic    q_pop;
    logic    res_valid;
    result_t res_data;
    logic    res_ready;

    // register file, word addressed by paddr[2]
    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_marker_reg <= START_MARKER_RESET;
            end_marker_reg   <= END_MARKER_RESET;
        end else if (cfg_write) begin
            case (paddr[2])
                REG_START_MARKER: start_marker_reg <= pwdata[7:0];
                REG_END_MARKER:   end_marker_reg   <= pwdata[7:0];
                default:          start_marker_reg <= start_marker_reg;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_START_MARKER: prdata = {24'd0, start_marker_reg};
            REG_END_MARKER:   prdata = {24'd0, end_marker_reg};
            default:          prdata = 32'd0;
        endcase
    end

    // front: accept and classify bytes into the queue
    bfdr_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .start_marker (start_marker_reg),
        .end_marker   (end_marker_reg),
        .q_valid      (q_valid),
        .q_item       (q_item),
        .q_pop        (q_pop)
    );

    // back: parser, payload store, resync and frame emission
    bfdr_engine u_engine (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .start_marker (start_marker_reg),
        .end_marker   (end_marker_reg),
        .q_valid      (q_valid),
        .q_item       (q_item),
        .q_pop        (q_pop),
        .res_valid    (res_valid),
        .res_data     (res_data),
        .res_ready    (res_ready)
    );

    // output register toward the result stream
    bfdr_out u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res_valid (res_valid),
        .res_data  (res_data),
        .res_ready (res_ready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

`ifndef SYNTHESIS
    // engine only pops a queue that holds an item
    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> q_valid)
        else $error("engine popped an empty queue");

    // after the last item of a frame is handed over, the engine goes quiet
    a_last_ends_run: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && res_ready && res_data.last_of_frame) |=> !res_valid)
        else $error("result offered right after last of frame");

    // an empty frame yields a single cleared item
    a_empty_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && !res_data.has_data) |->
        (res_data.last_of_frame && res_data.byte_index == '0 &&
         res_data.data_byte == 8'd0 && res_data.frame_length == '0))
        else $error("malformed empty frame item");

    // payload index stays inside the frame
    a_index_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && res_data.has_data) |->
        ({1'b0, res_data.byte_index} < res_data.frame_length))
        else $error("byte index beyond frame length");
`endif

endmodule

### test/byte_frame_deframer_resync_top_tb.sv
module byte_frame_deframer_resync_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bfdr_pkg::*;

    // cycles with no item moving on either side before the run is called hung
    localparam int QUIET_LIMIT = 20000;
    // drain time once nothing is expected (resync chains walk the store)
    localparam int SETTLE_CYCLES = 1000;
    localparam int RANDOM_PHASES = 8;
    localparam int BYTES_PER_PHASE = 44;

    // predicts the frame items from the received bytes and checks the outputs
    class frame_scoreboard;
        logic [7:0] start_mk;
        logic [7:0] end_mk;
        phase_t     ph;
        logic [7:0] id_held;
        int unsigned len_held;
        int unsigned fill;
        logic [7:0] payload_copy [MAX_PAYLOAD];
        int unsigned rpos;
        int unsigned rlim;
        result_t    frame_items_due [$];
        int unsigned errors;

        function new();
            start_mk = START_MARKER_RESET;
            end_mk   = END_MARKER_RESET;
            ph       = PH_IDLE;
            id_held  = '0;
            len_held = 0;
            fill     = 0;
            rpos     = 0;
            rlim     = 0;
            errors   = 0;
            foreach (payload_copy[i]) payload_copy[i] = '0;
        endfunction

        function void write_marker(logic which, logic [7:0] value);
            if (which == REG_START_MARKER) start_mk = value;
            else end_mk = value;
        endfunction

        // one byte through the parser, returns the number of items it caused
        function int parse_byte(logic [7:0] b);
            int n;
            int unsigned i;
            int unsigned flen;
            int unsigned found;
            int unsigned rem;
            bit hit;
            result_t r;
            n = 0;
            case (ph)
                PH_GET_ID: begin
                    id_held = b;
                    ph = PH_GET_LENGTH;
                end
                PH_GET_LENGTH: begin
                    if (b == 0) begin
                        len_held = 0;
                        ph = PH_GET_END;
                    end else if (b > MAX_PAYLOAD) begin
                        ph = PH_ERROR;
                    end else begin
                        len_held = b;
                        fill = 0;
                        ph = PH_GET_DATA;
                    end
                end
                PH_GET_DATA: begin
                    if (fill < MAX_PAYLOAD) payload_copy[fill] = b;
                    fill++;
                    if (fill >= len_held) begin
                        fill = 0;
                        ph = PH_GET_END;
                    end
                end
                PH_GET_END: begin
                    flen = (len_held > MAX_PAYLOAD) ? MAX_PAYLOAD : len_held;
                    if (b == end_mk) begin
                        ph = PH_IDLE;
                        rpos = 0;
                        rlim = 0;
                        r.frame_id     = id_held;
                        r.frame_length = LEN_W'(len_held);
                        if (flen == 0) begin
                            // empty frame: one item without data
                            r.byte_index    = '0;
                            r.data_byte     = '0;
                            r.has_data      = 1'b0;
                            r.last_of_frame = 1'b1;
                            frame_items_due.push_back(r);
                            n = 1;
                        end else begin
                            for (i = 0; i < flen; i++) begin
                                r.byte_index    = ADDR_W'(i);
                                r.data_byte     = payload_copy[i];
                                r.has_data      = 1'b1;
                                r.last_of_frame = (i + 1 == flen);
                                frame_items_due.push_back(r);
                            end
                            n = flen;
                        end
                    end else if (b == start_mk) begin
                        ph = PH_GET_ID;
                    end else begin
                        // resync: last start marker in the payload, scanned backward
                        ph = PH_ERROR;
                        hit = 0;
                        found = 0;
                        for (i = flen; i > 0; i--) begin
                            if (payload_copy[i-1] == start_mk) begin
                                found = i - 1;
                                hit = 1;
                                break;
                            end
                        end
                        if (hit) begin
                            ph = PH_GET_ID;
                            rem = 0;
                            // bytes still pending from an earlier replay go after the new span
                            if (rlim > rpos && rlim <= MAX_PAYLOAD && flen <= rpos) begin
                                rem = rlim - rpos;
                                for (i = 0; i < rem; i++)
                                    payload_copy[flen+i] = payload_copy[rpos+i];
                            end
                            rpos = found + 1;
                            rlim = flen + rem;
                        end
                    end
                end
                default: begin
                    ph = (b == start_mk) ? PH_GET_ID : PH_ERROR;
                end
            endcase
            return n;
        endfunction

        function void note_rx_byte(logic [7:0] b);
            int n;
            logic [7:0] nb;
            rpos = 0;
            rlim = 0;
            n = parse_byte(b);
            // replay stops as soon as a frame completes
            while (n == 0 && rpos < rlim && rpos < MAX_PAYLOAD) begin
                nb = payload_copy[rpos];
                rpos++;
                n = parse_byte(nb);
            end
            rpos = 0;
            rlim = 0;
        endfunction

        function void report_field(string name, int unsigned exp_v, int unsigned got_v);
            $display("%0t mismatch in %s: expected 0x%0h, actual 0x%0h",
                     $time, name, exp_v, got_v);
            errors++;
        endfunction

        function void check_frame_item(logic [31:0] tdata, logic tuser, logic tlast);
            result_t e;
            if (frame_items_due.size() == 0) begin
                $display("%0t unexpected item: expected none, actual tdata 0x%0h tuser %0b tlast %0b",
                         $time, tdata, tuser, tlast);
                errors++;
                return;
            end
            e = frame_items_due.pop_front();
            if (tdata[7:0] !== e.frame_id)
                report_field("frame_id", e.frame_id, tdata[7:0]);
            if (tdata[14:8] !== e.frame_length)
                report_field("frame_length", e.frame_length, tdata[14:8]);
            if (tdata[20:15] !== e.byte_index)
                report_field("byte_index", e.byte_index, tdata[20:15]);
            if (tdata[28:21] !== e.data_byte)
                report_field("data_byte", e.data_byte, tdata[28:21]);
            if (tuser !== e.has_data)
                report_field("has_data", e.has_data, tuser);
            if (tlast !== e.last_of_frame)
                report_field("last_of_frame", e.last_of_frame, tlast);
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    frame_scoreboard sb = new();

    // idling percentages, changed per phase
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned quiet_cycles = 0;

    // byte plan for the current phase and the markers it is built for
    logic [7:0] rx_plan [$];
    logic [7:0] cur_start = START_MARKER_RESET;
    logic [7:0] cur_end   = END_MARKER_RESET;

    byte_frame_deframer_resync_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // 4 ns clock
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // receiver side: stall at random, decided at each falling edge
    always @(negedge aclk) begin
        m_tready = ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // sample both handshakes at the rising edge
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready)
                sb.note_rx_byte(s_tdata);
            if (m_tvalid && m_tready)
                sb.check_frame_item(m_tdata, m_tuser, m_tlast);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
    end

    // watchdog: nothing moving for too long means a hang
    initial begin
        @(posedge aclk);
        while (quiet_cycles < QUIET_LIMIT) @(posedge aclk);
        $display("CHECK FAILED");
        $finish;
    end

    // apb write: setup cycle, then access until pready
    task automatic apb_write(logic which, logic [7:0] value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {which, 2'b00};
        pwdata  = {24'b0, value};
        @(negedge aclk);
        penable = 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        sb.write_marker(which, value);
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // push one item, called and left at a falling edge
    task automatic send_byte(logic [7:0] b);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = b;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    // send the whole plan, then wait until every frame item is out and the engine drained
    task automatic run_plan();
        while (rx_plan.size() != 0)
            send_byte(rx_plan.pop_front());
        s_tvalid = 1'b0;
        while (sb.frame_items_due.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        @(negedge aclk);
    endtask

    // payload byte: start markers are common so resyncs find something
    function automatic logic [7:0] pick_payload_byte();
        if ($urandom_range(0, 99) < 12) return cur_start;
        return 8'($urandom_range(0, 255));
    endfunction

    // mostly short frames, a few long ones and full capacity now and then
    function automatic int unsigned pick_length();
        int unsigned x;
        x = $urandom_range(0, 99);
        if (x < 4) return MAX_PAYLOAD;
        if (x < 8) return $urandom_range(9, MAX_PAYLOAD - 1);
        return $urandom_range(0, 8);
    endfunction

    // one random chunk: good frame, broken frame, oversize length or noise
    task automatic add_chunk();
        int unsigned kind;
        int unsigned len;
        int unsigned i;
        logic [7:0] bad;
        kind = $urandom_range(0, 99);
        if (kind < 55) begin
            len = pick_length();
            rx_plan.push_back(cur_start);
            rx_plan.push_back(8'($urandom_range(0, 255)));
            rx_plan.push_back(8'(len));
            for (i = 0; i < len; i++) rx_plan.push_back(pick_payload_byte());
            rx_plan.push_back(cur_end);
        end else if (kind < 72) begin
            len = $urandom_range(1, 8);
            rx_plan.push_back(cur_start);
            rx_plan.push_back(8'($urandom_range(0, 255)));
            rx_plan.push_back(8'(len));
            for (i = 0; i < len; i++) rx_plan.push_back(pick_payload_byte());
            // wrong end marker: either the start marker or anything else
            bad = ($urandom_range(0, 3) == 0) ? cur_start : 8'($urandom_range(0, 255));
            if (bad == cur_end) bad = cur_end ^ 8'h01;
            rx_plan.push_back(bad);
            // a well-formed tail lets a restart or a replay finish a frame
            if ($urandom_range(0, 1)) begin
                len = $urandom_range(0, 4);
                rx_plan.push_back(8'($urandom_range(0, 255)));
                rx_plan.push_back(8'(len));
                for (i = 0; i < len; i++) rx_plan.push_back(pick_payload_byte());
                rx_plan.push_back(cur_end);
            end
        end else if (kind < 82) begin
            rx_plan.push_back(cur_start);
            rx_plan.push_back(8'($urandom_range(0, 255)));
            rx_plan.push_back(8'($urandom_range(MAX_PAYLOAD + 1, 255)));
        end else begin
            repeat ($urandom_range(1, 3)) rx_plan.push_back(8'($urandom_range(0, 255)));
        end
    endtask

    initial begin
        int unsigned p;
        logic [7:0] st;
        logic [7:0] en;

        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        m_tready = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;

        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed part on the reset markers 0xff / 0x00
        // oversize length
        rx_plan = {8'hff, 8'h01, 8'h41};
        // restart when the start marker stands where the end marker belongs,
        // coming out of error; then an empty frame
        rx_plan = {rx_plan, 8'hff, 8'h07, 8'h00, 8'hff, 8'h02, 8'h00, 8'h00};
        // wrong end with no start marker in the payload
        rx_plan = {rx_plan, 8'hff, 8'h04, 8'h01, 8'h33, 8'h77};
        // resync whose replay completes an empty frame, leftover replay dropped
        rx_plan = {rx_plan, 8'hff, 8'h05, 8'h05, 8'hff, 8'h06, 8'h00, 8'h00, 8'haa, 8'h55};
        // resync with the marker inside the payload, replay leaves a frame open
        rx_plan = {rx_plan, 8'hff, 8'h03, 8'h03, 8'h11, 8'hff, 8'h22, 8'h99};
        run_plan();

        for (p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0: begin st = 8'hff; en = 8'h00; end
                1: begin st = 8'h00; en = 8'hff; end
                2: begin st = 8'h7e; en = 8'h7d; end
                3: begin st = 8'h80; en = 8'h01; end
                4: begin st = 8'h5a; en = 8'h5a; end   // equal markers
                7: begin st = 8'hff; en = 8'h00; end
                default: begin
                    st = 8'($urandom_range(0, 255));
                    en = 8'($urandom_range(0, 255));
                end
            endcase
            apb_write(REG_START_MARKER, st);
            apb_write(REG_END_MARKER, en);
            cur_start = st;
            cur_end   = en;

            // idling mode: none, sender idle, receiver stall, both lightly
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 64; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 64; end
                default: begin send_idle_pct = 19; recv_stall_pct = 19; end
            endcase

            while (rx_plan.size() < BYTES_PER_PHASE) add_chunk();
            run_plan();
        end

        if (sb.errors == 0 && sb.frame_items_due.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

### sim.f
rtl/core/bfdr_pkg.sv
rtl/core/bfdr_front.sv
rtl/core/bfdr_engine.sv
rtl/core/bfdr_out.sv
rtl/core/byte_frame_deframer_resync_top.sv
test/byte_frame_deframer_resync_top_tb.sv
